// ===== sv/jts_pkg.sv =====
// Shared types and constants of the JSON token scanner.
// Holds token kinds, the token and token-bundle structs and position helpers.
// No dependencies.
package jts_pkg;

   // Width of the running byte position; offsets wrap at this width
   localparam int POS_BITS   = 32;
   // Width of token_start and token_length on the result channel
   localparam int OUT_BITS   = 32;
   // Most tokens that one byte can produce
   localparam int MAX_TOKENS = 3;
   localparam int CNT_BITS   = $clog2(MAX_TOKENS + 1);
   localparam int IDX_BITS   = $clog2(MAX_TOKENS);

   typedef logic [POS_BITS-1:0] pos_type;
   typedef logic [3:0]          kind_type;

   localparam kind_type KIND_COMMA      = 4'd0;
   localparam kind_type KIND_COLON      = 4'd1;
   localparam kind_type KIND_OBJ_OPEN   = 4'd2;
   localparam kind_type KIND_OBJ_CLOSE  = 4'd3;
   localparam kind_type KIND_ARR_OPEN   = 4'd4;
   localparam kind_type KIND_ARR_CLOSE  = 4'd5;
   localparam kind_type KIND_STRING     = 4'd6;
   localparam kind_type KIND_NUMBER     = 4'd7;
   localparam kind_type KIND_TRUE       = 4'd8;
   localparam kind_type KIND_FALSE      = 4'd9;
   localparam kind_type KIND_NULL       = 4'd10;
   localparam kind_type KIND_EOF        = 4'd11;
   localparam kind_type KIND_BAD_ESCAPE = 4'd12;
   localparam kind_type KIND_INCOMPLETE = 4'd13;
   localparam kind_type KIND_UNEXPECTED = 4'd14;

   typedef struct packed {
      kind_type            kind;
      logic [OUT_BITS-1:0] start;
      logic [OUT_BITS-1:0] length;
   } token_type;

   // All tokens produced by one byte, in order
   typedef struct packed {
      logic [CNT_BITS-1:0]              count;
      token_type [MAX_TOKENS-1:0]       tokens;
   } bundle_type;

   // Fit a position to the result field width
   function automatic logic [OUT_BITS-1:0] out_pos(pos_type p);
      return OUT_BITS'(p);
   endfunction

endpackage

// ===== sv/jts_req_if.sv =====
// Input channel of the JSON token scanner: one document byte per transfer.
// Depends on nothing but the valid/ready handshake convention.
interface jts_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       final_byte;

   modport source (output valid, text_byte, final_byte, input ready);
   modport sink   (input valid, text_byte, final_byte, output ready);
endinterface

// ===== sv/jts_rsp_if.sv =====
// Result channel of the JSON token scanner: one token per transfer.
// Depends on jts_pkg for field widths.
interface jts_rsp_if;
   import jts_pkg::*;

   logic                valid;
   logic                ready;
   kind_type            token_kind;
   logic [OUT_BITS-1:0] token_start;
   logic [OUT_BITS-1:0] token_length;
   logic                run_end;

   modport source (output valid, token_kind, token_start, token_length, run_end,
                   input ready);
   modport sink   (input valid, token_kind, token_start, token_length, run_end,
                   output ready);
endinterface

// ===== sv/jts_scan_core.sv =====
// Lexer state and the per-byte step: mode, number grammar, escapes, literals.
// Produces the bundle of tokens for the presented byte. Depends on jts_pkg.
module jts_scan_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         text_byte,
   input  logic               final_byte,
   output jts_pkg::bundle_type bundle
);
   import jts_pkg::*;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_STRING  = 3'd1,
      MODE_NUMBER  = 3'd2,
      MODE_LITERAL = 3'd3,
      MODE_BADWORD = 3'd4,
      MODE_DRAIN   = 3'd5
   } mode_type;

   typedef logic [3:0] phase_type;
   localparam phase_type NP_START = 4'd0;
   localparam phase_type NP_SIGN1 = 4'd1;
   localparam phase_type NP_SIGN2 = 4'd2;
   localparam phase_type NP_ZERO  = 4'd3;
   localparam phase_type NP_DIG1  = 4'd4;
   localparam phase_type NP_DIG2  = 4'd5;
   localparam phase_type NP_DIG3  = 4'd6;
   localparam phase_type NP_DOT   = 4'd7;
   localparam phase_type NP_EXP   = 4'd8;
   localparam phase_type NP_BAD   = 4'd15;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

   function automatic logic is_ws(logic [7:0] c);
      return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
   endfunction

   function automatic logic is_dig(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_hex(logic [7:0] c);
      return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic is_delim(logic [7:0] c);
      return is_ws(c) || c == "," || c == "}" || c == "]";
   endfunction

   function automatic logic is_escape(logic [7:0] c);
      return c == CH_QUOTE || c == CH_BSLASH || c == "/" || c == "b" ||
             c == "f" || c == "n" || c == "r" || c == "t";
   endfunction

   function automatic logic accepting(phase_type ph);
      return ph == NP_ZERO || ph == NP_DIG1 || ph == NP_DIG2 || ph == NP_DIG3;
   endfunction

   // Number grammar transition
   function automatic phase_type number_next(phase_type ph, logic [7:0] c);
      logic      e;
      phase_type r;
      e = (c == "e" || c == "E");
      unique case (ph)
         NP_START: r = (c == "-") ? NP_SIGN1 :
                       (c == "0") ? NP_ZERO : (is_dig(c) ? NP_DIG1 : NP_BAD);
         NP_SIGN1: r = (c == "0") ? NP_ZERO : (is_dig(c) ? NP_DIG1 : NP_BAD);
         NP_SIGN2: r = is_dig(c) ? NP_DIG3 : NP_BAD;
         NP_ZERO:  r = (c == ".") ? NP_DOT : (e ? NP_EXP : NP_BAD);
         NP_DIG1:  r = (c == ".") ? NP_DOT :
                       (e ? NP_EXP : (is_dig(c) ? NP_DIG1 : NP_BAD));
         NP_DIG2:  r = e ? NP_EXP : (is_dig(c) ? NP_DIG2 : NP_BAD);
         NP_DIG3:  r = is_dig(c) ? NP_DIG3 : NP_BAD;
         NP_DOT:   r = is_dig(c) ? NP_DIG2 : NP_BAD;
         NP_EXP:   r = (c == "+" || c == "-") ? NP_SIGN2 :
                       (is_dig(c) ? NP_DIG3 : NP_BAD);
         default:  r = NP_BAD;
      endcase
      return r;
   endfunction

   // Literal words: 0 true, 1 false, 2 null
   function automatic logic [2:0] lit_len(logic [1:0] w);
      return (w == 2'd1) ? 3'd5 : 3'd4;
   endfunction

   function automatic logic [7:0] lit_char(logic [1:0] w, logic [2:0] i);
      logic [7:0] r;
      r = 8'h00;
      unique case (w)
         2'd0: unique case (i)
                  3'd0: r = "t";
                  3'd1: r = "r";
                  3'd2: r = "u";
                  3'd3: r = "e";
                  default: r = 8'h00;
               endcase
         2'd1: unique case (i)
                  3'd0: r = "f";
                  3'd1: r = "a";
                  3'd2: r = "l";
                  3'd3: r = "s";
                  3'd4: r = "e";
                  default: r = 8'h00;
               endcase
         2'd2: unique case (i)
                  3'd0: r = "n";
                  3'd1: r = "u";
                  3'd2: r = "l";
                  3'd3: r = "l";
                  default: r = 8'h00;
               endcase
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   mode_type   mode_ff, mode_in;
   phase_type  phase_ff, phase_in;
   logic       esc_ff, esc_in;
   logic [2:0] hex_ff, hex_in;
   logic [1:0] lit_word_ff, lit_word_in;
   logic [2:0] lit_idx_ff, lit_idx_in;
   pos_type    pos_ff, pos_in;
   pos_type    origin_ff, origin_in;
   pos_type    resume_ff, resume_in;

   logic [CNT_BITS-1:0]        cnt;
   token_type [MAX_TOKENS-1:0] toks;
   logic                       run_idle;
   phase_type                  nx;
   logic [1:0]                 w;
   pos_type                    p;
   pos_type                    nxt;
   pos_type                    u;

   // Advance the lexer by one byte and collect the tokens it closes
   always_comb begin
      mode_in     = mode_ff;
      phase_in    = phase_ff;
      esc_in      = esc_ff;
      hex_in      = hex_ff;
      lit_word_in = lit_word_ff;
      lit_idx_in  = lit_idx_ff;
      origin_in   = origin_ff;
      resume_in   = resume_ff;
      cnt         = '0;
      toks        = '0;
      run_idle    = 1'b0;
      p           = pos_ff;
      nxt         = pos_ff + 1'b1;
      u           = '0;
      nx          = number_next(phase_ff, text_byte);
      w           = (lit_word_ff == 2'd3) ? 2'd0 : lit_word_ff;

      unique case (mode_ff)
         MODE_IDLE: run_idle = 1'b1;
         MODE_STRING: begin
            if (hex_ff != 3'd0) begin
               if (is_hex(text_byte)) begin
                  hex_in = hex_ff - 1'b1;
               end else begin
                  // report up to the u of the escape
                  u = p - pos_type'(3'd5 - hex_ff);
                  toks[cnt[IDX_BITS-1:0]] = '{KIND_BAD_ESCAPE, out_pos(origin_ff),
                                              out_pos(u - origin_ff)};
                  cnt = cnt + 1'b1;
                  mode_in = MODE_DRAIN;
               end
            end else if (esc_ff) begin
               esc_in = 1'b0;
               if (text_byte == "u") begin
                  hex_in = 3'd4;
               end else if (!is_escape(text_byte)) begin
                  toks[cnt[IDX_BITS-1:0]] = '{KIND_BAD_ESCAPE, out_pos(origin_ff),
                                              out_pos(p - origin_ff)};
                  cnt = cnt + 1'b1;
                  mode_in = MODE_DRAIN;
               end
            end else if (text_byte == CH_QUOTE) begin
               toks[cnt[IDX_BITS-1:0]] = '{KIND_STRING, out_pos(origin_ff),
                                           out_pos(p - origin_ff)};
               cnt = cnt + 1'b1;
               mode_in   = MODE_IDLE;
               resume_in = nxt;
            end else if (text_byte == CH_BSLASH) begin
               esc_in = 1'b1;
            end
         end
         MODE_NUMBER: begin
            if (nx != NP_BAD) begin
               phase_in = nx;
            end else if (accepting(phase_ff) && is_delim(text_byte)) begin
               // close the number, then handle the delimiter as between tokens
               toks[cnt[IDX_BITS-1:0]] = '{KIND_NUMBER, out_pos(origin_ff),
                                           out_pos(p - origin_ff)};
               cnt = cnt + 1'b1;
               resume_in = p;
               mode_in   = MODE_IDLE;
               run_idle  = 1'b1;
            end else begin
               toks[cnt[IDX_BITS-1:0]] = '{KIND_UNEXPECTED, out_pos(p), out_pos(pos_type'(1))};
               cnt = cnt + 1'b1;
               mode_in = MODE_DRAIN;
            end
         end
         MODE_LITERAL: begin
            if (lit_idx_ff < lit_len(w) && lit_char(w, lit_idx_ff) == text_byte) begin
               lit_idx_in = lit_idx_ff + 1'b1;
               if (lit_idx_in >= lit_len(w)) begin
                  toks[cnt[IDX_BITS-1:0]] = '{KIND_TRUE + kind_type'(w), out_pos(origin_ff),
                                              out_pos(pos_type'(lit_len(w)))};
                  cnt = cnt + 1'b1;
                  mode_in   = MODE_IDLE;
                  resume_in = nxt;
               end
            end else begin
               mode_in = MODE_BADWORD;
            end
         end
         default: ;
      endcase

      // Between tokens: skip whitespace, emit punctuation, open a token or flag a bad byte
      if (run_idle) begin
         if (is_ws(text_byte)) begin
            mode_in = MODE_IDLE;
         end else if (text_byte == "," || text_byte == ":" || text_byte == "{" ||
                      text_byte == "}" || text_byte == "[" || text_byte == "]") begin
            unique case (text_byte)
               ",":     toks[cnt[IDX_BITS-1:0]].kind = KIND_COMMA;
               ":":     toks[cnt[IDX_BITS-1:0]].kind = KIND_COLON;
               "{":     toks[cnt[IDX_BITS-1:0]].kind = KIND_OBJ_OPEN;
               "}":     toks[cnt[IDX_BITS-1:0]].kind = KIND_OBJ_CLOSE;
               "[":     toks[cnt[IDX_BITS-1:0]].kind = KIND_ARR_OPEN;
               default: toks[cnt[IDX_BITS-1:0]].kind = KIND_ARR_CLOSE;
            endcase
            toks[cnt[IDX_BITS-1:0]].start  = out_pos(p);
            toks[cnt[IDX_BITS-1:0]].length = out_pos(pos_type'(1));
            cnt = cnt + 1'b1;
            resume_in = nxt;
         end else if (text_byte == CH_QUOTE) begin
            mode_in   = MODE_STRING;
            origin_in = nxt;
            esc_in    = 1'b0;
            hex_in    = 3'd0;
         end else if (text_byte == "-" || is_dig(text_byte)) begin
            mode_in   = MODE_NUMBER;
            origin_in = p;
            phase_in  = number_next(NP_START, text_byte);
         end else if (text_byte == "t" || text_byte == "f" || text_byte == "n") begin
            mode_in     = MODE_LITERAL;
            lit_word_in = (text_byte == "t") ? 2'd0 : ((text_byte == "f") ? 2'd1 : 2'd2);
            lit_idx_in  = 3'd1;
            origin_in   = p;
         end else begin
            toks[cnt[IDX_BITS-1:0]] = '{KIND_UNEXPECTED, out_pos(p), out_pos(pos_type'(1))};
            cnt = cnt + 1'b1;
            mode_in = MODE_DRAIN;
         end
      end

      // Final byte: close what is open, then return to the reset state
      if (final_byte) begin
         unique case (mode_in)
            MODE_IDLE: begin
               toks[cnt[IDX_BITS-1:0]] = '{KIND_EOF, out_pos(resume_in),
                                           out_pos(nxt - resume_in)};
               cnt = cnt + 1'b1;
            end
            MODE_STRING: begin
               if (hex_in != 3'd0) begin
                  u = p - pos_type'(3'd4 - hex_in);
                  toks[cnt[IDX_BITS-1:0]] = '{KIND_BAD_ESCAPE, out_pos(origin_in),
                                              out_pos(u - origin_in)};
               end else begin
                  toks[cnt[IDX_BITS-1:0]] = '{KIND_INCOMPLETE, out_pos(origin_in),
                                              out_pos(nxt - origin_in)};
               end
               cnt = cnt + 1'b1;
            end
            MODE_NUMBER: begin
               if (accepting(phase_in)) begin
                  toks[cnt[IDX_BITS-1:0]] = '{KIND_NUMBER, out_pos(origin_in),
                                              out_pos(nxt - origin_in)};
                  cnt = cnt + 1'b1;
                  toks[cnt[IDX_BITS-1:0]] = '{KIND_EOF, out_pos(nxt), out_pos(pos_type'(0))};
               end else begin
                  toks[cnt[IDX_BITS-1:0]] = '{KIND_INCOMPLETE, out_pos(origin_in),
                                              out_pos(nxt - origin_in)};
               end
               cnt = cnt + 1'b1;
            end
            MODE_LITERAL: begin
               toks[cnt[IDX_BITS-1:0]] = '{KIND_INCOMPLETE, out_pos(origin_in),
                                           out_pos(nxt - origin_in)};
               cnt = cnt + 1'b1;
            end
            MODE_BADWORD: begin
               toks[cnt[IDX_BITS-1:0]] = '{KIND_UNEXPECTED, out_pos(origin_in),
                                           out_pos(nxt - origin_in)};
               cnt = cnt + 1'b1;
            end
            default: ;
         endcase
         mode_in     = MODE_IDLE;
         phase_in    = NP_START;
         esc_in      = 1'b0;
         hex_in      = 3'd0;
         lit_word_in = 2'd0;
         lit_idx_in  = 3'd0;
         pos_in      = '0;
         origin_in   = '0;
         resume_in   = '0;
      end else begin
         pos_in = nxt;
      end

      bundle.count  = cnt;
      bundle.tokens = toks;
   end

   // Hold lexer state; update on each input transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         phase_ff    <= NP_START;
         esc_ff      <= 1'b0;
         hex_ff      <= 3'd0;
         lit_word_ff <= 2'd0;
         lit_idx_ff  <= 3'd0;
         pos_ff      <= '0;
         origin_ff   <= '0;
         resume_ff   <= '0;
      end else if (step) begin
         mode_ff     <= mode_in;
         phase_ff    <= phase_in;
         esc_ff      <= esc_in;
         hex_ff      <= hex_in;
         lit_word_ff <= lit_word_in;
         lit_idx_ff  <= lit_idx_in;
         pos_ff      <= pos_in;
         origin_ff   <= origin_in;
         resume_ff   <= resume_in;
      end
   end

endmodule

// ===== sv/jts_emit.sv =====
// Result register of the JSON token scanner: holds one byte's tokens and
// hands them out one per transfer. Depends on jts_pkg and jts_rsp_if.
module jts_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  jts_pkg::bundle_type bundle,
   output logic                load_ready,
   jts_rsp_if.source           rsp
);
   import jts_pkg::*;

   logic [CNT_BITS-1:0]        left_ff, left_in;
   logic [IDX_BITS-1:0]        idx_ff, idx_in;
   token_type [MAX_TOKENS-1:0] toks_ff, toks_in;
   logic                       take;

   assign take       = rsp.valid && rsp.ready;
   // Accept a new bundle once the last held token leaves
   assign load_ready = (left_ff == '0) || (left_ff == CNT_BITS'(1) && rsp.ready);

   // Drive the current token
   assign rsp.valid        = (left_ff != '0);
   assign rsp.token_kind   = toks_ff[idx_ff].kind;
   assign rsp.token_start  = toks_ff[idx_ff].start;
   assign rsp.token_length = toks_ff[idx_ff].length;
   assign rsp.run_end      = (left_ff == CNT_BITS'(1));

   // Load a bundle or step to the next token
   always_comb begin
      left_in = left_ff;
      idx_in  = idx_ff;
      toks_in = toks_ff;
      if (load) begin
         left_in = bundle.count;
         idx_in  = '0;
         toks_in = bundle.tokens;
      end else if (take) begin
         left_in = left_ff - 1'b1;
         idx_in  = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         idx_ff  <= '0;
      end else begin
         left_ff <= left_in;
         idx_ff  <= idx_in;
      end
      toks_ff <= toks_in;
   end

endmodule

// ===== sv/json_token_scanner.sv =====
// Top level of the JSON token scanner: lexer step plus result register.
// Depends on jts_pkg, jts_req_if, jts_rsp_if, jts_scan_core and jts_emit.
//
//   channel   direction  payload                                     transfer
//   req_bus   in         text_byte[7:0], final_byte                  valid & ready
//   rsp_bus   out        token_kind[3:0], token_start[31:0],         valid & ready
//                        token_length[31:0], run_end
//
// One byte per cycle while each byte closes at most one token and rsp_bus does
// not stall; a byte that closes two or three tokens keeps req_bus.ready low
// until its last token is left; the result register sends one per unstalled cycle.
// The first token of a byte appears on rsp_bus the cycle after the byte transfers.
// Synchronous reset clears the lexer state and empties the result register.
// A stall on rsp_bus holds the current token; a new byte is still taken in the
// cycle that the last held token leaves.
module json_token_scanner (
   input  logic    clock,
   input  logic    reset,
   jts_req_if.sink   req_bus,
   jts_rsp_if.source rsp_bus
);
   import jts_pkg::*;

   bundle_type bundle;
   logic       load_ready;
   logic       step;

   assign req_bus.ready = load_ready;
   assign step          = req_bus.valid && load_ready;

   jts_scan_core u_scan_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .text_byte  (req_bus.text_byte),
      .final_byte (req_bus.final_byte),
      .bundle     (bundle)
   );

   jts_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (step),
      .bundle     (bundle),
      .load_ready (load_ready),
      .rsp        (rsp_bus)
   );

endmodule

// ===== sv/jts_checker.sv =====
// Port-level checks for the JSON token scanner, bound to the top level.
// Depends on jts_pkg and on the top level's channel ports.
module jts_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input jts_pkg::kind_type             rsp_token_kind,
   input logic [jts_pkg::OUT_BITS-1:0]  rsp_token_start,
   input logic [jts_pkg::OUT_BITS-1:0]  rsp_token_length,
   input logic                          rsp_run_end
);
   import jts_pkg::*;

   // Hold a stalled token unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_token_kind) &&
      $stable(rsp_token_start) && $stable(rsp_token_length) && $stable(rsp_run_end))
      else $error("stalled token changed");

   // Input stalls only while tokens wait to leave
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no token pending");

   // End of input always closes the run of its byte
   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == KIND_EOF |-> rsp_run_end)
      else $error("end of input token not last of its byte");

   // Keep the token kind within the defined range
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_token_kind <= KIND_UNEXPECTED)
      else $error("token kind out of range");

endmodule

bind json_token_scanner jts_checker u_jts_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_token_kind   (rsp_bus.token_kind),
   .rsp_token_start  (rsp_bus.token_start),
   .rsp_token_length (rsp_bus.token_length),
   .rsp_run_end      (rsp_bus.run_end)
);
